// ----- src/dps_pkg.sv -----
// dps_pkg: shared types and constants of the drill press sequencer
// request payload structs, phase codes, register indexes and the hole-spacing pattern
// no dependencies
package dps_pkg;

  typedef struct packed {
    logic [2:0] sensor_bits;
    logic       start_req;
  } dps_in_t;

  typedef struct packed {
    logic [4:0] control_word;
    logic       busy_res;
    logic [1:0] run_status;
  } dps_out_t;

  typedef enum logic [14:0] {
    PH_IDLE     = 15'b000000000000001,
    PH_REF_A    = 15'b000000000000010,
    PH_REF_B    = 15'b000000000000100,
    PH_REF_C    = 15'b000000000001000,
    PH_SPIN     = 15'b000000000010000,
    PH_TST_A    = 15'b000000000100000,
    PH_TST_B    = 15'b000000001000000,
    PH_TST_C    = 15'b000000010000000,
    PH_DD_WAIT  = 15'b000000100000000,
    PH_UP_OK    = 15'b000001000000000,
    PH_DONE_OK  = 15'b000010000000000,
    PH_UP_BAD   = 15'b000100000000000,
    PH_DONE_BAD = 15'b001000000000000,
    PH_ALM_STOP = 15'b010000000000000,
    PH_ALM_HOLE = 15'b100000000000000
  } dps_phase_e;

  // configuration register indexes
  localparam logic [1:0] CFG_DOWN_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_ALARM_PULSES = 2'd1;

  localparam logic [7:0] DOWN_TIMEOUT_RST = 8'd20;
  localparam logic [3:0] ALARM_PULSES_RST = 4'd2;

  // run status codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  // control word bit positions
  localparam int unsigned CW_STEP    = 0;
  localparam int unsigned CW_DIR     = 1;
  localparam int unsigned CW_SPINDLE = 2;
  localparam int unsigned CW_FEED    = 3;
  localparam int unsigned CW_ALARM   = 4;

  // sensor bit positions
  localparam int unsigned SN_REF   = 0;
  localparam int unsigned SN_MOTOR = 1;
  localparam int unsigned SN_DOWN  = 2;

  localparam logic [7:0] TABLE_END = 8'd255;

  // alarm pulse: two quiet ticks, four ticks with the alarm on
  localparam logic [7:0] ALARM_ON_TICK  = 8'd2;
  localparam logic [7:0] ALARM_END_TICK = 8'd6;

  localparam int unsigned PATTERN_LEN = 21;
  localparam logic [7:0] HOLE_PATTERN [PATTERN_LEN] = '{
    8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd1, 8'd5,
    8'd2, 8'd2, 8'd2, 8'd2, 8'd4, 8'd4, 8'd3, 8'd8, 8'd2, 8'd255
  };

  // fixed hole-spacing entry, terminator past the pattern
  function automatic logic [7:0] hole_spacing(logic [7:0] idx);
    logic [7:0] val;
    val = TABLE_END;
    if (idx < 8'(PATTERN_LEN)) begin
      val = HOLE_PATTERN[idx[4:0]];
    end
    return val;
  endfunction

endpackage

// ----- src/dps_table.sv -----
// dps_table: hole-spacing memory, one write and one registered read port
// filled from the pattern in dps_pkg by a sweep after reset
module dps_table import dps_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  output logic          fill_busy_o
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] fill_cnt_q;
  logic          fill_busy_q;
  logic [7:0]    rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      fill_busy_q <= 1'b1;
    end else if (fill_busy_q) begin
      if (fill_cnt_q == AW'(DEPTH - 1)) begin
        fill_busy_q <= 1'b0;
      end else begin
        fill_cnt_q <= fill_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_busy_q) begin
      mem[fill_cnt_q] <= hole_spacing(8'(fill_cnt_q));
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o   = rd_data_q;
  assign fill_busy_o = fill_busy_q;

endmodule

// ----- src/dps_skid.sv -----
// dps_skid: two-entry output buffer for result requests
// depends on dps_pkg for the result struct
module dps_skid import dps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dps_out_t in_data_i,
  output logic     skid_full_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dps_out_t out_data_o
);

  logic     out_valid_q, skid_valid_q;
  dps_out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_valid_i) begin
        out_q <= in_data_i;
      end
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/dps_core.sv -----
// dps_core: sequencer state and per-tick update
// depends on dps_pkg; reads the spacing table through a registered memory port
module dps_core import dps_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned TIW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  dps_in_t       in_data_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output dps_out_t      result_o
);

  dps_phase_e     phase_q, phase_d;
  logic [7:0]     tick_q, tick_d;
  logic [7:0]     steps_q, steps_d;
  logic [TIW-1:0] index_q, index_d;
  logic [3:0]     pulses_q, pulses_d;
  logic [4:0]     ctrl_q, ctrl_d;
  logic [1:0]     status_q, status_d;
  logic [7:0]     down_timeout_q;
  logic [3:0]     alarm_pulses_q;

  always_comb begin
    logic [2:0]  s;
    logic        do_fetch, do_ref, do_nstep, do_drill, do_dd;
    logic        do_abegin, do_aend, do_finish;
    logic [1:0]  fin_st;
    dps_phase_e  ctx;
    logic [7:0]  v;

    s         = in_data_i.sensor_bits;
    phase_d   = phase_q;
    tick_d    = tick_q;
    steps_d   = steps_q;
    index_d   = index_q;
    pulses_d  = pulses_q;
    ctrl_d    = ctrl_q;
    status_d  = status_q;
    do_fetch  = 1'b0;
    do_ref    = 1'b0;
    do_nstep  = 1'b0;
    do_drill  = 1'b0;
    do_dd     = 1'b0;
    do_abegin = 1'b0;
    do_aend   = 1'b0;
    do_finish = 1'b0;
    fin_st    = ST_NONE;
    ctx       = PH_ALM_STOP;
    v         = TABLE_END;

    unique case (phase_q)
      PH_REF_A: begin
        ctrl_d[CW_STEP] = 1'b1;
        phase_d         = PH_REF_B;
      end
      PH_TST_A: begin
        ctrl_d[CW_STEP] = 1'b1;
        phase_d         = PH_TST_B;
      end
      PH_REF_B: phase_d = PH_REF_C;
      PH_TST_B: phase_d = PH_TST_C;
      PH_REF_C: begin
        ctrl_d[CW_STEP] = 1'b0;
        do_ref          = 1'b1;
      end
      PH_TST_C: begin
        ctrl_d[CW_STEP] = 1'b0;
        steps_d         = steps_q - 1'b1;
        do_nstep        = 1'b1;
      end
      PH_SPIN, PH_DONE_OK: do_fetch = 1'b1;
      PH_DD_WAIT: do_dd = 1'b1;
      PH_UP_OK: begin
        ctrl_d[CW_FEED] = 1'b0;
        phase_d         = PH_DONE_OK;
      end
      PH_UP_BAD: begin
        ctrl_d[CW_FEED] = 1'b0;
        phase_d         = PH_DONE_BAD;
      end
      PH_DONE_BAD: begin
        do_finish = 1'b1;
        fin_st    = ST_FAULT;
      end
      PH_ALM_STOP, PH_ALM_HOLE: begin
        if (tick_q >= ALARM_END_TICK) begin
          ctrl_d[CW_ALARM] = 1'b0;
          pulses_d         = pulses_q - 1'b1;
          if (pulses_d != 4'd0) begin
            tick_d = 8'd1;
          end else begin
            do_aend = 1'b1;
            ctx     = phase_q;
          end
        end else begin
          if (tick_q == ALARM_ON_TICK) begin
            ctrl_d[CW_ALARM] = 1'b1;
          end
          tick_d = tick_q + 1'b1;
        end
      end
      PH_IDLE: begin
        do_ref = in_data_i.start_req;
      end
      default: phase_d = PH_IDLE;
    endcase

    // table fetch; reads past the end count as the terminator
    if (do_fetch) begin
      if (index_q < TIW'(DEPTH)) begin
        v       = rd_data_i;
        index_d = index_q + 1'b1;
      end
      if (v == TABLE_END) begin
        do_finish = 1'b1;
        fin_st    = ST_OK;
      end else begin
        steps_d  = v;
        do_nstep = 1'b1;
      end
    end

    // homing check
    if (do_ref) begin
      if (s[SN_REF]) begin
        ctrl_d[CW_SPINDLE] = 1'b1;
        index_d            = '0;
        phase_d            = PH_SPIN;
      end else if (!s[SN_MOTOR]) begin
        do_abegin = 1'b1;
        ctx       = PH_ALM_STOP;
      end else begin
        ctrl_d[CW_DIR] = 1'b1;
        phase_d        = PH_REF_A;
      end
    end

    if (do_nstep) begin
      if (steps_d == 8'd0) begin
        do_drill = 1'b1;
      end else if (!s[SN_MOTOR]) begin
        do_abegin = 1'b1;
        ctx       = PH_ALM_STOP;
      end else begin
        ctrl_d[CW_DIR] = 1'b1;
        phase_d        = PH_TST_A;
      end
    end

    if (do_drill) begin
      ctrl_d[CW_FEED] = 1'b1;
      tick_d          = 8'd0;
      do_dd           = 1'b1;
    end

    // drill-down wait with timeout
    if (do_dd) begin
      if (tick_d < down_timeout_q) begin
        if (s[SN_DOWN]) begin
          phase_d = PH_UP_OK;
        end else begin
          tick_d  = tick_d + 1'b1;
          phase_d = PH_DD_WAIT;
        end
      end else begin
        do_abegin = 1'b1;
        ctx       = PH_ALM_HOLE;
      end
    end

    if (do_abegin) begin
      pulses_d = alarm_pulses_q;
      if (alarm_pulses_q == 4'd0) begin
        do_aend = 1'b1;
      end else begin
        tick_d  = 8'd1;
        phase_d = ctx;
      end
    end

    if (do_aend) begin
      if (ctx == PH_ALM_STOP) begin
        do_finish = 1'b1;
        fin_st    = ST_FAULT;
      end else begin
        phase_d = PH_UP_BAD;
      end
    end

    if (do_finish) begin
      ctrl_d[CW_SPINDLE] = 1'b0;
      status_d           = fin_st;
      phase_d            = PH_IDLE;
      tick_d             = 8'd0;
      steps_d            = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      steps_q  <= '0;
      index_q  <= '0;
      pulses_q <= '0;
      ctrl_q   <= '0;
      status_q <= ST_NONE;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      steps_q  <= steps_d;
      index_q  <= index_d;
      pulses_q <= pulses_d;
      ctrl_q   <= ctrl_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_timeout_q <= DOWN_TIMEOUT_RST;
      alarm_pulses_q <= ALARM_PULSES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DOWN_TIMEOUT: down_timeout_q <= cfg_data_i;
        CFG_ALARM_PULSES: alarm_pulses_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // read the entry that the next tick will need
  assign rd_addr_o = step_i ? index_d[AW-1:0] : index_q[AW-1:0];

  assign result_o.control_word = ctrl_d;
  assign result_o.busy_res     = (phase_d != PH_IDLE);
  assign result_o.run_status   = status_d;

endmodule

// ----- src/drill_press_sequencer_top.sv -----
// drill_press_sequencer_top: top level of the drill press sequencer
// depends on dps_pkg, dps_table, dps_core and dps_skid
//
// usage
// - input channel: one request per delay tick, carrying sensor_bits and start_req
// - output channel: one result request per tick: control word, busy flag, run status
// - config channel: index 0 down_timeout, index 1 alarm_pulses; other indexes ignored,
//   always ready; the user must write it only while no tick is in flight (unchecked by the block)
// - result path: the result of an accepted tick is registered into the output buffer, which drives out_data_o
// - throughput: one tick per clock cycle while in_ready_o is high; the tick update is one pass of the
//   sequencer logic, and the next spacing entry is prefetched from the table
//   memory's registered read port so it never stalls a tick
// - reset: the table memory is loaded with the hole pattern by a sweep over all
//   TABLE_DEPTH entries; in_ready_o stays low until it ends, config is taken
// - receiver stall: a two-entry output buffer holds results; one more tick is
//   taken while a result waits, then in_ready_o drops until the skid entry empties
module drill_press_sequencer_top import dps_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dps_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dps_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic          fill_busy;
  logic          skid_full;
  logic          in_fire;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  dps_out_t      result;

  // ticks wait for the table fill and for room in the output buffer
  assign in_ready_o  = !fill_busy && !skid_full;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  dps_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .fill_busy_o (fill_busy)
  );

  dps_core #(
    .DEPTH (TABLE_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .result_o    (result)
  );

  // result buffer toward the receiver
  dps_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_fire),
    .in_data_i   (result),
    .skid_full_o (skid_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a tick taken against a stalled receiver lands in the skid entry
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_o && !out_ready_i) |=> (out_valid_o && !in_ready_o))
    else $error("tick accepted during stall not buffered");

  // no tick while the table is still loading
  a_fill_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(fill_busy) && fill_busy) |-> !in_fire)
    else $error("tick accepted during table fill");

  // an idle result never shows the spindle running
  a_idle_spindle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.busy_res) |-> !out_data_o.control_word[CW_SPINDLE])
    else $error("spindle on while idle");

  // status code stays in range
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.run_status != 2'd3))
    else $error("invalid run status");

endmodule
